// ===== sv/tpc_pkg.sv =====
// Shared types, register codes and the triangle cut table of the plane clipper.
package tpc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PaddrW = 5;
  localparam logic [16:0] RatioOne = 17'h10000;

  localparam logic [2:0] REG_NRM_X = 3'd0;
  localparam logic [2:0] REG_NRM_Y = 3'd1;
  localparam logic [2:0] REG_NRM_Z = 3'd2;
  localparam logic [2:0] REG_PT_X  = 3'd3;
  localparam logic [2:0] REG_PT_Y  = 3'd4;
  localparam logic [2:0] REG_PT_Z  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIDE_MUL,
    ST_SIDE_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_LOAD,
    ST_EDGE_MUL,
    ST_EDGE_ACC,
    ST_EMIT
  } seq_state_e;

  typedef logic [4:0][31:0] vert_t;

  typedef struct packed {
    logic [1:0]      n;
    logic [8:0][2:0] idx;
  } plan_t;

  function automatic logic signed [1:0] sgn(input logic signed [31:0] s);
    logic signed [1:0] g;
    if (s > 0) g = 2'sd1;
    else if (s < 0) g = -2'sd1;
    else g = 2'sd0;
    return g;
  endfunction

  // Vertices 0..2 are the input corners, 3..5 the split points on edges
  // 0-1, 0-2 and 1-2.
  function automatic plan_t cut_plan(input logic signed [31:0] s0, s1, s2);
    plan_t p;
    logic signed [1:0] g1, g2;
    p.n   = 2'd1;
    p.idx = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0};
    g1 = sgn(s1);
    g2 = sgn(s2);
    if (s0 == 0) begin
      if (!(g1 == g2 && g1 != 0)) begin
        p.n   = 2'd2;
        p.idx = {3'd0, 3'd0, 3'd0, 3'd2, 3'd5, 3'd0, 3'd5, 3'd1, 3'd0};
      end
    end else begin
      if (s0 < 0) begin
        g1 = -g1;
        g2 = -g2;
      end
      if (g1 > 0) begin
        if (g2 < 0) begin
          p.n   = 2'd3;
          p.idx = {3'd2, 3'd5, 3'd4, 3'd0, 3'd4, 3'd5, 3'd5, 3'd1, 3'd0};
        end
      end else if (g1 == 0) begin
        if (g2 < 0) begin
          p.n   = 2'd2;
          p.idx = {3'd0, 3'd0, 3'd0, 3'd2, 3'd1, 3'd4, 3'd4, 3'd1, 3'd0};
        end
      end else if (g2 > 0) begin
        p.n   = 2'd3;
        p.idx = {3'd5, 3'd1, 3'd3, 3'd5, 3'd3, 3'd2, 3'd2, 3'd3, 3'd0};
      end else if (g2 == 0) begin
        p.n   = 2'd2;
        p.idx = {3'd0, 3'd0, 3'd0, 3'd2, 3'd1, 3'd3, 3'd2, 3'd3, 3'd0};
      end else begin
        p.n   = 2'd3;
        p.idx = {3'd3, 3'd2, 3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd0};
      end
    end
    return p;
  endfunction

endpackage

// ===== sv/tpc_vtx_if.sv =====
// Input vertex channel: valid/ready handshake with one textured vertex.
interface tpc_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// ===== sv/tpc_res_if.sv =====
// Output vertex channel: valid/ready handshake with one clipped vertex.
interface tpc_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_u;
  logic signed [31:0] out_v;
  logic [1:0]         triangle_number;
  logic [1:0]         triangle_total;
  logic               last_of_triangle;
  logic               last;

  modport source (output valid, out_x, out_y, out_z, out_u, out_v, triangle_number,
                  triangle_total, last_of_triangle, last, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_u, out_v, triangle_number,
                  triangle_total, last_of_triangle, last, output ready);
endinterface

// ===== sv/tpc_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
module tpc_mul (
  input  logic               clk_i,
  input  logic signed [32:0] op_a_i,
  input  logic signed [32:0] op_b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/tpc_div.sv =====
// Restoring divider for the edge ratio, one quotient bit per cycle, result capped at one.
module tpc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [16:0] quo_q, quo_d;
  logic [34:0] trial;

  assign trial = {rem_q, 1'b0} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      den_d = den_i;
      rem_d = {2'b00, num_i};
      cnt_d = 5'd16;
      quo_d = '0;
      // A numerator not below the denominator (zero denominator included)
      // gives a ratio of at least one.
      if ({1'b0, num_i} >= den_i) begin
        quo_d  = tpc_pkg::RatioOne;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!trial[34]) begin
        rem_d = trial[33:0];
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = {rem_q[32:0], 1'b0};
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/triangle_plane_clipper_core.sv =====
// Triangle plane clipper top level: config registers, vertex store and sequencer.
//
// Vertices enter on vtx_in one at a time; the first two are only stored and
// are taken as soon as they are valid. The third starts the cut and the input
// stays not ready until every result vertex has been loaded into the output
// register. The cut runs on one shared multiplier and one radix-2 divider: it
// first computes the three plane distances, then for each edge divides for the
// ratio, fetches the edge start and interpolates. The first of 3, 6 or 9 result
// vertices then appears on res_out, and one follows per cycle while the
// receiver holds ready high. res_out has a single output register; when the
// receiver holds ready low the sequencer waits with the next vertex and nothing
// is lost. The input is taken again while the last result vertex still waits
// in that register. The user writes the plane through the APB port while the
// block is idle; the block itself does not enforce this. Registers read back
// as written. Reset clears the plane to zero and the vertex count.
module triangle_plane_clipper_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpc_pkg::PaddrW-1:0]      paddr,
  input  logic [tpc_pkg::DataW-1:0]       pwdata,
  output logic [tpc_pkg::DataW-1:0]       prdata,
  output logic                            pready,
  tpc_vtx_if.sink                         vtx_in,
  tpc_res_if.source                       res_out
);

  logic signed [31:0] nrm_q [3];
  logic signed [31:0] pt_q  [3];
  logic [2:0]         reg_sel;

  tpc_pkg::vert_t     vert_q [6];
  tpc_pkg::vert_t     va_q;
  tpc_pkg::vert_t     rd_vert;
  logic [2:0]         rd_addr;

  tpc_pkg::seq_state_e state_q, state_d;
  logic [1:0]  vcnt_q, vcnt_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [2:0]  fld_q, fld_d;
  logic        term_q, term_d;
  logic [3:0]  k_q, k_d;
  logic [1:0]  tri_q, tri_d;
  logic [1:0]  cor_q, cor_d;

  logic signed [66:0] acc_q, acc_d;
  logic signed [31:0] s_q [3];
  logic [16:0]        r_q;
  logic [16:0]        w;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic signed [66:0] side_sum, tex_sum;

  logic [2:0]  ea, eb;
  logic signed [31:0] sa, sb;
  logic signed [32:0] sdiff;
  logic [31:0] div_num;
  logic [32:0] div_den;
  logic        div_start, div_done;
  logic [16:0] div_quo;

  tpc_pkg::plan_t plan;
  logic        out_load;
  logic        out_valid_q;

  // Configuration port
  assign reg_sel = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= '0;
        pt_q[i]  <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        tpc_pkg::REG_NRM_X: nrm_q[0] <= pwdata;
        tpc_pkg::REG_NRM_Y: nrm_q[1] <= pwdata;
        tpc_pkg::REG_NRM_Z: nrm_q[2] <= pwdata;
        tpc_pkg::REG_PT_X:  pt_q[0]  <= pwdata;
        tpc_pkg::REG_PT_Y:  pt_q[1]  <= pwdata;
        tpc_pkg::REG_PT_Z:  pt_q[2]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tpc_pkg::REG_NRM_X: prdata = nrm_q[0];
      tpc_pkg::REG_NRM_Y: prdata = nrm_q[1];
      tpc_pkg::REG_NRM_Z: prdata = nrm_q[2];
      tpc_pkg::REG_PT_X:  prdata = pt_q[0];
      tpc_pkg::REG_PT_Y:  prdata = pt_q[1];
      tpc_pkg::REG_PT_Z:  prdata = pt_q[2];
      default:            prdata = '0;
    endcase
  end

  // Edge endpoints: edge 0 is 0-1, edge 1 is 0-2, edge 2 is 1-2.
  assign ea      = (cnt_q == 2'd2) ? 3'd1 : 3'd0;
  assign eb      = (cnt_q == 2'd0) ? 3'd1 : 3'd2;
  assign sa      = s_q[ea[1:0]];
  assign sb      = s_q[eb[1:0]];
  assign sdiff   = {sa[31], sa} - {sb[31], sb};
  assign div_num = sb[31] ? (~sb + 32'd1) : sb;
  assign div_den = sdiff[32] ? (~sdiff + 33'd1) : sdiff;
  assign div_start = (state_q == tpc_pkg::ST_DIV_START);
  assign w       = tpc_pkg::RatioOne - r_q;

  assign plan = tpc_pkg::cut_plan(s_q[0], s_q[1], s_q[2]);

  always_comb begin
    case (state_q)
      tpc_pkg::ST_SIDE_MUL: rd_addr = {1'b0, cnt_q};
      tpc_pkg::ST_LOAD:     rd_addr = ea;
      tpc_pkg::ST_EDGE_MUL: rd_addr = eb;
      tpc_pkg::ST_EMIT:     rd_addr = plan.idx[k_q];
      default:              rd_addr = 3'd0;
    endcase
  end
  assign rd_vert = vert_q[rd_addr];

  // Operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == tpc_pkg::ST_SIDE_MUL) begin
      op_a = {nrm_q[fld_q[1:0]][31], nrm_q[fld_q[1:0]]};
      op_b = {rd_vert[fld_q][31], rd_vert[fld_q]}
           - {pt_q[fld_q[1:0]][31], pt_q[fld_q[1:0]]};
    end else if (state_q == tpc_pkg::ST_EDGE_MUL) begin
      if (fld_q < 3'd3) begin
        op_a = {16'd0, w};
        op_b = {rd_vert[fld_q][31], rd_vert[fld_q]} - {va_q[fld_q][31], va_q[fld_q]};
      end else if (!term_q) begin
        op_a = {16'd0, r_q};
        op_b = {va_q[fld_q][31], va_q[fld_q]};
      end else begin
        op_a = {16'd0, w};
        op_b = {rd_vert[fld_q][31], rd_vert[fld_q]};
      end
    end
  end

  tpc_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  tpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign side_sum = ((fld_q == 3'd0) ? 67'sd0 : acc_q) + {{17{prod[65]}}, prod[65:16]};
  assign tex_sum  = acc_q + {prod[65], prod};

  assign out_load = (state_q == tpc_pkg::ST_EMIT) && (!out_valid_q || res_out.ready);
  assign vtx_in.ready = (state_q == tpc_pkg::ST_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    vcnt_d  = vcnt_q;
    cnt_d   = cnt_q;
    fld_d   = fld_q;
    term_d  = term_q;
    k_d     = k_q;
    tri_d   = tri_q;
    cor_d   = cor_q;
    acc_d   = acc_q;
    case (state_q)
      tpc_pkg::ST_IDLE: begin
        if (vtx_in.valid) begin
          if (vcnt_q == 2'd2) begin
            vcnt_d  = 2'd0;
            cnt_d   = 2'd0;
            fld_d   = 3'd0;
            state_d = tpc_pkg::ST_SIDE_MUL;
          end else begin
            vcnt_d = vcnt_q + 2'd1;
          end
        end
      end
      tpc_pkg::ST_SIDE_MUL: state_d = tpc_pkg::ST_SIDE_ACC;
      tpc_pkg::ST_SIDE_ACC: begin
        acc_d = side_sum;
        if (fld_q == 3'd2) begin
          fld_d = 3'd0;
          if (cnt_q == 2'd2) begin
            cnt_d   = 2'd0;
            state_d = tpc_pkg::ST_DIV_START;
          end else begin
            cnt_d   = cnt_q + 2'd1;
            state_d = tpc_pkg::ST_SIDE_MUL;
          end
        end else begin
          fld_d   = fld_q + 3'd1;
          state_d = tpc_pkg::ST_SIDE_MUL;
        end
      end
      tpc_pkg::ST_DIV_START: state_d = tpc_pkg::ST_DIV_WAIT;
      tpc_pkg::ST_DIV_WAIT: begin
        if (div_done) state_d = tpc_pkg::ST_LOAD;
      end
      tpc_pkg::ST_LOAD: begin
        fld_d   = 3'd0;
        term_d  = 1'b0;
        state_d = tpc_pkg::ST_EDGE_MUL;
      end
      tpc_pkg::ST_EDGE_MUL: state_d = tpc_pkg::ST_EDGE_ACC;
      tpc_pkg::ST_EDGE_ACC: begin
        if (fld_q >= 3'd3 && !term_q) begin
          acc_d   = {prod[65], prod};
          term_d  = 1'b1;
          state_d = tpc_pkg::ST_EDGE_MUL;
        end else begin
          term_d = 1'b0;
          if (fld_q == 3'd4) begin
            fld_d = 3'd0;
            if (cnt_q == 2'd2) begin
              k_d     = '0;
              tri_d   = '0;
              cor_d   = '0;
              state_d = tpc_pkg::ST_EMIT;
            end else begin
              cnt_d   = cnt_q + 2'd1;
              state_d = tpc_pkg::ST_DIV_START;
            end
          end else begin
            fld_d   = fld_q + 3'd1;
            state_d = tpc_pkg::ST_EDGE_MUL;
          end
        end
      end
      tpc_pkg::ST_EMIT: begin
        if (out_load) begin
          k_d = k_q + 4'd1;
          if (cor_q == 2'd2) begin
            cor_d = 2'd0;
            tri_d = tri_q + 2'd1;
            if (tri_q == plan.n - 2'd1) state_d = tpc_pkg::ST_IDLE;
          end else begin
            cor_d = cor_q + 2'd1;
          end
        end
      end
      default: state_d = tpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpc_pkg::ST_IDLE;
      vcnt_q      <= '0;
      cnt_q       <= '0;
      fld_q       <= '0;
      term_q      <= 1'b0;
      k_q         <= '0;
      tri_q       <= '0;
      cor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vcnt_q  <= vcnt_d;
      cnt_q   <= cnt_d;
      fld_q   <= fld_d;
      term_q  <= term_d;
      k_q     <= k_d;
      tri_q   <= tri_d;
      cor_q   <= cor_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_out.ready) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (state_q == tpc_pkg::ST_IDLE && vtx_in.valid) begin
      vert_q[{1'b0, vcnt_q}] <= {vtx_in.tex_v, vtx_in.tex_u, vtx_in.pos_z,
                                 vtx_in.pos_y, vtx_in.pos_x};
    end
    if (state_q == tpc_pkg::ST_SIDE_ACC && fld_q == 3'd2) begin
      if (!side_sum[66] && (|side_sum[66:31])) s_q[cnt_q] <= 32'sh7FFFFFFF;
      else if (side_sum[66] && !(&side_sum[66:31])) s_q[cnt_q] <= 32'sh80000000;
      else s_q[cnt_q] <= side_sum[31:0];
    end
    if (state_q == tpc_pkg::ST_DIV_WAIT && div_done) r_q <= div_quo;
    if (state_q == tpc_pkg::ST_LOAD) va_q <= rd_vert;
    if (state_q == tpc_pkg::ST_EDGE_ACC) begin
      if (fld_q < 3'd3) begin
        vert_q[3'd3 + {1'b0, cnt_q}][fld_q] <= va_q[fld_q] + prod[47:16];
      end else if (term_q) begin
        vert_q[3'd3 + {1'b0, cnt_q}][fld_q] <= tex_sum[47:16];
      end
    end
    if (out_load) begin
      res_out.out_x            <= rd_vert[0];
      res_out.out_y            <= rd_vert[1];
      res_out.out_z            <= rd_vert[2];
      res_out.out_u            <= rd_vert[3];
      res_out.out_v            <= rd_vert[4];
      res_out.triangle_number  <= tri_q;
      res_out.triangle_total   <= plan.n;
      res_out.last_of_triangle <= (cor_q == 2'd2);
      res_out.last             <= (cor_q == 2'd2) && (tri_q == plan.n - 2'd1);
    end
  end

  assign res_out.valid = out_valid_q;

endmodule
